@@ design/gcba_pkg.sv @@
// ----------------------------------------------------------------------------
// gcba_pkg: shared types and constants of the grid cell box assigner
// Operation codes, register indexes, field widths and the table entry type.
// ----------------------------------------------------------------------------
package gcba_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int NO_LABEL_DEF   = 0;
  localparam int FILL_VALUE_DEF = 0;

  localparam int COORD_W = 12;
  localparam int LABEL_W = 8;
  localparam int OUT_W   = 21;
  localparam int CELL_W  = 13;
  localparam int GRID_SIDE = 3;
  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [2:0] REG_FIELD_W  = 3'd0;
  localparam logic [2:0] REG_FIELD_H  = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_LOW      = 3'd4;
  localparam logic [2:0] REG_HIGH     = 3'd5;
  localparam logic [2:0] REG_MODE     = 3'd6;

  typedef struct packed {
    logic [LABEL_W-1:0] lab;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } box_t;

  typedef struct packed {
    logic start;
    logic [OUT_W-1:0] value;
    logic [7:0] divisor;
  } div_req_t;

endpackage

@@ design/gcba_div.sv @@
// ----------------------------------------------------------------------------
// gcba_div: shared divider with a signed Q12.8 quotient
// Restoring divider, one quotient bit per cycle, round half away from zero,
// saturates to the signed 21-bit range.
// ----------------------------------------------------------------------------
module gcba_div (
  input  logic clk,
  input  logic rst_n,
  input  gcba_pkg::div_req_t req,
  output logic done,
  output logic [gcba_pkg::OUT_W-1:0] quot
);
  localparam int NUM_W = 30;
  localparam int CNT_W = 5;

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [7:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic [gcba_pkg::OUT_W-1:0] quot_r, quot_nxt;
  logic [gcba_pkg::OUT_W-1:0] mag;
  logic [9:0] trial;
  logic [NUM_W-1:0] qsat;

  assign mag = req.value[gcba_pkg::OUT_W-1] ? (~req.value + 1'b1) : req.value;
  assign trial = {rem_r, num_r[NUM_W-1]} - {2'b0, den_r};
  assign qsat = neg_r ? ((num_r > NUM_W'(1048576)) ? NUM_W'(1048576) : num_r)
                      : ((num_r > NUM_W'(1048575)) ? NUM_W'(1048575) : num_r);

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    busy_nxt = busy_r; cnt_nxt = cnt_r; done_nxt = 1'b0; quot_nxt = quot_r;
    if (req.start) begin
      den_nxt = (req.divisor == 8'd0) ? 8'd1 : req.divisor;
      // mag*256 + den/2
      num_nxt = {1'b0, mag, 8'd0} + NUM_W'(((req.divisor == 8'd0) ? 8'd1 : req.divisor) >> 1);
      neg_nxt = req.value[gcba_pkg::OUT_W-1];
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[9]) begin
        rem_nxt = trial[8:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[7:0], num_r[NUM_W-1]};
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(0)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        num_nxt = num_r;
        rem_nxt = rem_r;
        quot_nxt = neg_r ? (~qsat[gcba_pkg::OUT_W-1:0] + 1'b1) : qsat[gcba_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
    neg_r <= neg_nxt; quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

@@ design/grid_cell_box_assigner_unit.sv @@
// ----------------------------------------------------------------------------
// grid_cell_box_assigner_unit: grid cell box assigner
// Box table plus a sequencer that scans the table for each of nine cells
// and, with mode bit 1 set, normalizes matches through one shared divider.
// ----------------------------------------------------------------------------
//  channel | ports                      | handshake
//  in      | start, busy, in_*          | start & !busy
//  out     | out_valid, out_*           | one-cycle strobe, no stall
//  cfg     | cfg_we, cfg_index, cfg_data| cfg_we
// clear, add and unknown beats are taken while busy stays low.
// a query runs per cell S_CELL, then S_READ and S_TEST for each scanned entry
// up to the first match, then, when normalizing a match, S_DIV and S_WAIT for
// each of four divider runs, then S_EMIT; busy stays high to the ninth S_EMIT.
// reset empties the table; the receiver cannot stall results.
module grid_cell_box_assigner_unit #(
  parameter int MAX_BOXES  = gcba_pkg::MAX_BOXES_DEF,
  parameter int NO_LABEL   = gcba_pkg::NO_LABEL_DEF,
  parameter int FILL_VALUE = gcba_pkg::FILL_VALUE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_box_label,
  input  logic [11:0] in_box_left,
  input  logic [11:0] in_box_top,
  input  logic [11:0] in_box_right,
  input  logic [11:0] in_box_bottom,
  input  logic [11:0] in_patch_x,
  input  logic [11:0] in_patch_y,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  output logic [3:0] out_cell_index,
  output logic out_found,
  output logic [7:0] out_label,
  output logic signed [20:0] out_rel_left,
  output logic signed [20:0] out_rel_top,
  output logic signed [20:0] out_box_width,
  output logic signed [20:0] out_box_height,
  output logic [12:0] out_cell_x,
  output logic [12:0] out_cell_y,
  output logic out_last
);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CELL = 7'b0000010,
    S_READ = 7'b0000100,
    S_TEST = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  gcba_pkg::box_t mem [MAX_BOXES];
  gcba_pkg::box_t rd_r;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [7:0] fw_r, fh_r, sx_r, sy_r;
  logic [15:0] lo_r, hi_r;
  logic [1:0] mode_r;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;
  logic [12:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic found_r, found_nxt;
  logic [7:0] lab_r, lab_nxt;
  logic [20:0] v_r [4];
  logic [20:0] v_nxt [4];
  logic [1:0] dsel_r, dsel_nxt;
  logic act;
  logic [14:0] rx0, ry0, rx1, ry1;
  gcba_pkg::div_req_t dreq;
  logic ddone;
  logic [20:0] dq;
  logic ov_r, ov_nxt;
  logic [3:0] oci_r, oci_nxt;

  gcba_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (start && !busy && in_operation == gcba_pkg::OP_ADD && count_r < CW'(MAX_BOXES))
      mem[count_r[AW-1:0]] <= '{in_box_label, in_box_left, in_box_top,
                                in_box_right, in_box_bottom};
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 8'd16; fh_r <= 8'd16; sx_r <= 8'd8; sy_r <= 8'd8;
      lo_r <= 16'h0000; hi_r <= 16'h0F0F; mode_r <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcba_pkg::REG_FIELD_W: fw_r <= cfg_data[7:0];
        gcba_pkg::REG_FIELD_H: fh_r <= cfg_data[7:0];
        gcba_pkg::REG_STEP_X:  sx_r <= cfg_data[7:0];
        gcba_pkg::REG_STEP_Y:  sy_r <= cfg_data[7:0];
        gcba_pkg::REG_LOW:     lo_r <= cfg_data;
        gcba_pkg::REG_HIGH:    hi_r <= cfg_data;
        gcba_pkg::REG_MODE:    mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign rx0 = 15'(cx_r) + 15'(lo_r[7:0]);
  assign ry0 = 15'(cy_r) + 15'(lo_r[15:8]);
  assign rx1 = 15'(cx_r) + 15'(hi_r[7:0]);
  assign ry1 = 15'(cy_r) + 15'(hi_r[15:8]);

  always_comb begin
    if (mode_r[0])
      act = ({2'b0, rd_r.x0} + {2'b0, rd_r.x1}) >= {rx0[13:0], 1'b0} && rx0[14] == 1'b0 &&
            ({2'b0, rd_r.x0} + {2'b0, rd_r.x1}) <= {rx1[13:0], 1'b0} &&
            ({2'b0, rd_r.y0} + {2'b0, rd_r.y1}) >= {ry0[13:0], 1'b0} && ry0[14] == 1'b0 &&
            ({2'b0, rd_r.y0} + {2'b0, rd_r.y1}) <= {ry1[13:0], 1'b0};
    else
      act = 15'(rd_r.x0) >= rx0 && 15'(rd_r.x1) <= rx1 &&
            15'(rd_r.y0) >= ry0 && 15'(rd_r.y1) <= ry1;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r;
    row_nxt = row_r; col_nxt = col_r; cx_nxt = cx_r; cy_nxt = cy_r;
    found_nxt = found_r; lab_nxt = lab_r; dsel_nxt = dsel_r;
    ov_nxt = 1'b0; oci_nxt = oci_r;
    for (int i = 0; i < 4; i++) v_nxt[i] = v_r[i];
    dreq.start = 1'b0;
    dreq.value = v_r[dsel_r];
    dreq.divisor = dsel_r[0] ? fh_r : fw_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == gcba_pkg::OP_CLEAR) count_nxt = '0;
          else if (in_operation == gcba_pkg::OP_ADD) begin
            if (count_r < CW'(MAX_BOXES)) count_nxt = count_r + 1'b1;
          end else if (in_operation == gcba_pkg::OP_QUERY) begin
            row_nxt = '0; col_nxt = '0;
            cx_nxt = 13'(in_patch_x); cy_nxt = 13'(in_patch_y);
            state_nxt = S_CELL;
          end
        end
      end
      S_CELL: begin
        idx_nxt = '0; found_nxt = 1'b0;
        state_nxt = (count_r == '0) ? S_EMIT : S_READ;
      end
      S_READ: state_nxt = S_TEST;
      S_TEST: begin
        if (act) begin
          found_nxt = 1'b1;
          lab_nxt = rd_r.lab;
          v_nxt[0] = 21'($signed({1'b0, rd_r.x0}) - $signed({1'b0, cx_r}));
          v_nxt[1] = 21'($signed({1'b0, rd_r.y0}) - $signed({1'b0, cy_r}));
          v_nxt[2] = 21'($signed({1'b0, rd_r.x1}) - $signed({1'b0, rd_r.x0}) + 14'sd1);
          v_nxt[3] = 21'($signed({1'b0, rd_r.y1}) - $signed({1'b0, rd_r.y0}) + 14'sd1);
          dsel_nxt = '0;
          state_nxt = mode_r[1] ? S_DIV : S_EMIT;
        end else if (idx_r + 1'b1 >= count_r) state_nxt = S_EMIT;
        else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DIV: begin
        dreq.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (ddone) begin
          v_nxt[dsel_r] = dq;
          dsel_nxt = dsel_r + 1'b1;
          state_nxt = (dsel_r == 2'd3) ? S_EMIT : S_DIV;
        end
      end
      S_EMIT: begin
        ov_nxt = 1'b1;
        oci_nxt = 4'(row_r * 2'd3 + 4'(col_r));
        if (!found_r) begin
          lab_nxt = 8'(NO_LABEL);
          for (int i = 0; i < 4; i++) v_nxt[i] = 21'(FILL_VALUE);
        end
        state_nxt = S_CELL;
        if (col_r == 2'(gcba_pkg::GRID_SIDE - 1)) begin
          col_nxt = '0;
          cx_nxt = cx_r - 13'({sx_r, 1'b0});
          cy_nxt = cy_r + 13'(sy_r);
          row_nxt = row_r + 1'b1;
          if (row_r == 2'(gcba_pkg::GRID_SIDE - 1)) state_nxt = S_IDLE;
        end else begin
          col_nxt = col_r + 1'b1;
          cx_nxt = cx_r + 13'(sx_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [12:0] ocx_r, ocy_r;
  logic olast_r, ofound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt; row_r <= row_nxt; col_r <= col_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; found_r <= found_nxt;
    lab_r <= lab_nxt; dsel_r <= dsel_nxt; oci_r <= oci_nxt;
    for (int i = 0; i < 4; i++) v_r[i] <= v_nxt[i];
    if (state_r == S_EMIT) begin
      ocx_r <= cx_r; ocy_r <= cy_r; ofound_r <= found_r;
      olast_r <= (row_r == 2'(gcba_pkg::GRID_SIDE - 1)) &&
                 (col_r == 2'(gcba_pkg::GRID_SIDE - 1));
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_cell_index = oci_r;
  assign out_found = ofound_r;
  assign out_label = lab_r;
  assign out_rel_left = v_r[0];
  assign out_rel_top = v_r[1];
  assign out_box_width = v_r[2];
  assign out_box_height = v_r[3];
  assign out_cell_x = ocx_r;
  assign out_cell_y = ocy_r;
  assign out_last = olast_r;
endmodule

@@ tb/sv/tb_grid_cell_box_assigner_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_cell_box_assigner_unit: self-checking bench of the box assigner
// Drives clear, add, query and unknown beats with random gaps, keeps its own
// box table and register copy, predicts the nine cell beats of every query
// and checks each output beat in order. Registers change only while idle.
// ----------------------------------------------------------------------------
module tb_grid_cell_box_assigner_unit;

  typedef struct {
    logic [3:0]                  cell_index;
    logic                        found;
    logic [7:0]                  label;
    logic [gcba_pkg::OUT_W-1:0]  rel_left;
    logic [gcba_pkg::OUT_W-1:0]  rel_top;
    logic [gcba_pkg::OUT_W-1:0]  box_width;
    logic [gcba_pkg::OUT_W-1:0]  box_height;
    logic [gcba_pkg::CELL_W-1:0] cell_x;
    logic [gcba_pkg::CELL_W-1:0] cell_y;
    logic                        last;
  } cell_beat_t;

  class cell_scoreboard;
    gcba_pkg::box_t boxes[gcba_pkg::MAX_BOXES_DEF];
    int            count;
    logic [7:0]    fw, fh, sx, sy;
    logic [15:0]   lo, hi;
    logic [1:0]    mode;
    cell_beat_t    pending[$];
    int            errors;

    function new();
      count = 0; fw = 8'd16; fh = 8'd16; sx = 8'd8; sy = 8'd8;
      lo = 16'h0000; hi = 16'h0F0F; mode = 2'd0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        gcba_pkg::REG_FIELD_W: fw = v[7:0];
        gcba_pkg::REG_FIELD_H: fh = v[7:0];
        gcba_pkg::REG_STEP_X:  sx = v[7:0];
        gcba_pkg::REG_STEP_Y:  sy = v[7:0];
        gcba_pkg::REG_LOW:     lo = v;
        gcba_pkg::REG_HIGH:    hi = v;
        gcba_pkg::REG_MODE:    mode = v[1:0];
        default: ;
      endcase
    endfunction

    function longint q88(longint v, logic [7:0] d);
      longint den, mag, q;
      den = (d == 0) ? 1 : longint'(d);
      mag = (v < 0) ? -v : v;
      q = (mag * 256 + den / 2) / den;
      if (v < 0) q = -q;
      if (q > 1048575) q = 1048575;
      if (q < -1048576) q = -1048576;
      return q;
    endfunction

    function bit box_hit(gcba_pkg::box_t b, longint rx0, longint ry0,
                         longint rx1, longint ry1);
      longint x0, y0, x1, y1;
      x0 = b.x0; y0 = b.y0; x1 = b.x1; y1 = b.y1;
      if (mode[0])
        return (x0 + x1 >= 2 * rx0) && (x0 + x1 <= 2 * rx1) &&
               (y0 + y1 >= 2 * ry0) && (y0 + y1 <= 2 * ry1);
      return x0 >= rx0 && x1 <= rx1 && y0 >= ry0 && y1 <= ry1;
    endfunction

    function void note_item(logic [1:0] op, gcba_pkg::box_t b, logic [11:0] px,
                            logic [11:0] py);
      longint cx, cy, rl, rt, bw, bh;
      int hit;
      cell_beat_t e;
      if (op == gcba_pkg::OP_CLEAR) count = 0;
      else if (op == gcba_pkg::OP_ADD) begin
        if (count < gcba_pkg::MAX_BOXES_DEF) begin
          boxes[count] = b;
          count++;
        end
      end else if (op == gcba_pkg::OP_QUERY) begin
        for (int k = 0; k < gcba_pkg::NUM_CELLS; k++) begin
          cx = longint'(px) + (k % 3) * longint'(sx);
          cy = longint'(py) + (k / 3) * longint'(sy);
          hit = -1;
          for (int i = 0; i < count; i++)
            if (hit < 0 && box_hit(boxes[i], cx + lo[7:0], cy + lo[15:8],
                                   cx + hi[7:0], cy + hi[15:8]))
              hit = i;
          e.cell_index = 4'(k);
          e.cell_x = cx[gcba_pkg::CELL_W-1:0];
          e.cell_y = cy[gcba_pkg::CELL_W-1:0];
          e.last = (k == gcba_pkg::NUM_CELLS - 1);
          if (hit >= 0) begin
            rl = longint'(boxes[hit].x0) - cx;
            rt = longint'(boxes[hit].y0) - cy;
            bw = longint'(boxes[hit].x1) - longint'(boxes[hit].x0) + 1;
            bh = longint'(boxes[hit].y1) - longint'(boxes[hit].y0) + 1;
            if (mode[1]) begin
              rl = q88(rl, fw); rt = q88(rt, fh);
              bw = q88(bw, fw); bh = q88(bh, fh);
            end
            e.found = 1'b1;
            e.label = boxes[hit].lab;
          end else begin
            rl = gcba_pkg::FILL_VALUE_DEF; rt = gcba_pkg::FILL_VALUE_DEF;
            bw = gcba_pkg::FILL_VALUE_DEF; bh = gcba_pkg::FILL_VALUE_DEF;
            e.found = 1'b0;
            e.label = 8'(gcba_pkg::NO_LABEL_DEF);
          end
          e.rel_left = rl[gcba_pkg::OUT_W-1:0];
          e.rel_top = rt[gcba_pkg::OUT_W-1:0];
          e.box_width = bw[gcba_pkg::OUT_W-1:0];
          e.box_height = bh[gcba_pkg::OUT_W-1:0];
          pending = {pending, e};
        end
      end
    endfunction

    function void check_beat(cell_beat_t a);
      cell_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat cell %0d", a.cell_index);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (a.cell_index !== e.cell_index) begin
        $error("cell_index exp %0d got %0d", e.cell_index, a.cell_index); errors++;
      end
      if (a.found !== e.found) begin
        $error("found exp %0d got %0d", e.found, a.found); errors++;
      end
      if (a.label !== e.label) begin
        $error("label exp %0d got %0d", e.label, a.label); errors++;
      end
      if (a.rel_left !== e.rel_left) begin
        $error("rel_left exp %h got %h", e.rel_left, a.rel_left); errors++;
      end
      if (a.rel_top !== e.rel_top) begin
        $error("rel_top exp %h got %h", e.rel_top, a.rel_top); errors++;
      end
      if (a.box_width !== e.box_width) begin
        $error("box_width exp %h got %h", e.box_width, a.box_width); errors++;
      end
      if (a.box_height !== e.box_height) begin
        $error("box_height exp %h got %h", e.box_height, a.box_height); errors++;
      end
      if (a.cell_x !== e.cell_x) begin
        $error("cell_x exp %0d got %0d", e.cell_x, a.cell_x); errors++;
      end
      if (a.cell_y !== e.cell_y) begin
        $error("cell_y exp %0d got %0d", e.cell_y, a.cell_y); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n, start, busy, cfg_we;
  logic [1:0] in_operation;
  logic [7:0] in_box_label;
  logic [11:0] in_box_left, in_box_top, in_box_right, in_box_bottom;
  logic [11:0] in_patch_x, in_patch_y;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic out_valid, out_found, out_last;
  logic [3:0] out_cell_index;
  logic [7:0] out_label;
  logic signed [20:0] out_rel_left, out_rel_top, out_box_width, out_box_height;
  logic [12:0] out_cell_x, out_cell_y;

  cell_scoreboard sb;
  int idle_cycles;

  grid_cell_box_assigner_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_box_label(in_box_label),
    .in_box_left(in_box_left), .in_box_top(in_box_top),
    .in_box_right(in_box_right), .in_box_bottom(in_box_bottom),
    .in_patch_x(in_patch_x), .in_patch_y(in_patch_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_cell_index(out_cell_index),
    .out_found(out_found), .out_label(out_label),
    .out_rel_left(out_rel_left), .out_rel_top(out_rel_top),
    .out_box_width(out_box_width), .out_box_height(out_box_height),
    .out_cell_x(out_cell_x), .out_cell_y(out_cell_y), .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // output monitor and stall watchdog
  always @(posedge clk) begin
    cell_beat_t a;
    if (rst_n && out_valid) begin
      a.cell_index = out_cell_index; a.found = out_found; a.label = out_label;
      a.rel_left = out_rel_left; a.rel_top = out_rel_top;
      a.box_width = out_box_width; a.box_height = out_box_height;
      a.cell_x = out_cell_x; a.cell_y = out_cell_y; a.last = out_last;
      sb.check_beat(a);
    end
    if ((rst_n && out_valid) || (start && !busy) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, gcba_pkg::box_t b, logic [11:0] px,
                           logic [11:0] py);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; in_operation <= op; in_box_label <= b.lab;
    in_box_left <= b.x0; in_box_top <= b.y0;
    in_box_right <= b.x1; in_box_bottom <= b.y1;
    in_patch_x <= px; in_patch_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, b, px, py);
  endtask

  function automatic gcba_pkg::box_t rand_box(logic [11:0] bx, logic [11:0] by, bit wide);
    gcba_pkg::box_t b;
    b.lab = 8'($urandom);
    if (wide) begin
      b.x0 = 12'($urandom); b.y0 = 12'($urandom);
      b.x1 = 12'($urandom); b.y1 = 12'($urandom);
    end else begin
      b.x0 = 12'(bx + $urandom_range(0, 40)); b.y0 = 12'(by + $urandom_range(0, 40));
      b.x1 = 12'(b.x0 + $urandom_range(0, 12)); b.y1 = 12'(b.y0 + $urandom_range(0, 12));
    end
    return b;
  endfunction

  task automatic random_phase(int n);
    logic [11:0] bx, by;
    int r;
    bx = 12'($urandom); by = 12'($urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_item(gcba_pkg::OP_CLEAR, rand_box(12'd0, 12'd0, 1'b1),
                  12'($urandom), 12'($urandom));
      else if (r < 5)
        send_item(gcba_pkg::OP_RSVD, rand_box(12'd0, 12'd0, 1'b1),
                  12'($urandom), 12'($urandom));
      else if (r < 50)
        send_item(gcba_pkg::OP_ADD, rand_box(bx, by, r < 8),
                  12'($urandom), 12'($urandom));
      else if (r < 95)
        send_item(gcba_pkg::OP_QUERY, rand_box(12'd0, 12'd0, 1'b1),
                  12'(bx + $urandom_range(0, 30) - 10),
                  12'(by + $urandom_range(0, 30) - 10));
      else
        send_item(gcba_pkg::OP_QUERY, rand_box(12'd0, 12'd0, 1'b1),
                  12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    gcba_pkg::box_t b;
    sb = new();
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_operation = 0; in_box_label = 0; in_box_left = 0; in_box_top = 0;
    in_box_right = 0; in_box_bottom = 0; in_patch_x = 0; in_patch_y = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, edge boxes, full table, unknown op
    b = '{lab: 8'hFF, x0: 12'd2, y0: 12'd3, x1: 12'd10, y1: 12'd12};
    send_item(gcba_pkg::OP_QUERY, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_ADD, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_ADD,
              '{lab: 8'd0, x0: 12'hFFF, y0: 12'hFFF, x1: 12'd0, y1: 12'd0},
              12'd0, 12'd0);
    send_item(gcba_pkg::OP_ADD,
              '{lab: 8'd7, x0: 12'hFF0, y0: 12'hFF0, x1: 12'hFFF, y1: 12'hFFF},
              12'd0, 12'd0);
    send_item(gcba_pkg::OP_QUERY, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_QUERY, b, 12'hFF0, 12'hFF0);
    send_item(gcba_pkg::OP_QUERY, b, 12'hFFF, 12'hFFF);
    send_item(gcba_pkg::OP_RSVD, b, 12'd0, 12'd0);
    wait_drained();
    write_reg(gcba_pkg::REG_MODE, 16'd3);
    write_reg(gcba_pkg::REG_FIELD_W, 16'd0);
    write_reg(gcba_pkg::REG_FIELD_H, 16'd255);
    write_reg(gcba_pkg::REG_STEP_X, 16'd255);
    write_reg(gcba_pkg::REG_STEP_Y, 16'd0);
    write_reg(gcba_pkg::REG_LOW, 16'hFFFF);
    write_reg(gcba_pkg::REG_HIGH, 16'hFFFF);
    send_item(gcba_pkg::OP_QUERY, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_QUERY, b, 12'hF00, 12'hF00);
    wait_drained();
    write_reg(gcba_pkg::REG_LOW, 16'h0000);
    write_reg(gcba_pkg::REG_MODE, 16'd2);
    send_item(gcba_pkg::OP_QUERY, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_CLEAR, b, 12'd0, 12'd0);
    for (int i = 0; i < 66; i++)
      send_item(gcba_pkg::OP_ADD, rand_box(12'd0, 12'd0, 1'b0), 12'd0, 12'd0);
    send_item(gcba_pkg::OP_QUERY, b, 12'd0, 12'd0);
    send_item(gcba_pkg::OP_CLEAR, b, 12'd0, 12'd0);
    wait_drained();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gcba_pkg::REG_FIELD_W, 16'($urandom_range(0, 255)));
      write_reg(gcba_pkg::REG_FIELD_H, 16'($urandom_range(1, 255)));
      write_reg(gcba_pkg::REG_STEP_X, 16'($urandom_range(0, 16)));
      write_reg(gcba_pkg::REG_STEP_Y, 16'($urandom_range(0, 16)));
      write_reg(gcba_pkg::REG_LOW, (ph == 5) ? 16'h2020 : {8'($urandom_range(0, 4)),
                                                           8'($urandom_range(0, 4))});
      write_reg(gcba_pkg::REG_HIGH, (ph == 4) ? 16'hFFFF : {8'($urandom_range(8, 40)),
                                                            8'($urandom_range(8, 40))});
      write_reg(gcba_pkg::REG_MODE, 16'(ph % 4));
      send_item(gcba_pkg::OP_CLEAR, rand_box(12'd0, 12'd0, 1'b1), 12'd0, 12'd0);
      random_phase(55);
      wait_drained();
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
